// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. They need clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksum frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  // Frame end status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_LEN_ERR  = 2'd1,
    STATUS_HDR_ERR  = 2'd2,
    STATUS_DATA_ERR = 2'd3
  } status_e;

  // Header byte positions
  localparam logic [3:0] PosLenHi     = 4'd0;
  localparam logic [3:0] PosLenCmpLo  = 4'd3;
  localparam logic [3:0] PosHeadCheck = 4'd10;
  localparam logic [3:0] PosDataCheck = 4'd11;
  localparam logic [3:0] HeaderBytes  = 4'd12;

  localparam logic [7:0] ByteMask = 8'hFF;

endpackage

`default_nettype wire

// File: design/checksum_frame_receiver.sv
// ----------------------------------------------------------------------------
// checksum_frame_receiver
// Byte-wise frame receiver: header capture, length complement, header and
// payload checksums, payload pass-through.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+-----------
//  in      | in_valid_i/in_ready_o, rx_byte  | sink
//  out     | out_valid_o/out_ready_i, fields | source
//
//  One byte per cycle while the output is taken: the frame state updates in
//  the accept cycle, and the result is registered in a single output register.
//  in_ready_o is high while the output register is empty or being drained.
//  Reset clears the frame state to zero and empties the output register.
//  A stalled output holds its item and stops input until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module checksum_frame_receiver (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            data_byte_o,
  output logic                  data_valid_o,
  output logic                  frame_end_o,
  output cfr_pkg::status_e      status_o,
  output logic [15:0]           to_address_o,
  output logic [15:0]           from_address_o,
  output logic [15:0]           command_o,
  output logic [15:0]           frame_length_o
);
  import cfr_pkg::*;

  // frame state
  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic        in_payload_q, in_payload_d;
  logic [15:0] len_q, len_d;
  logic [15:0] len_cmp_q, len_cmp_d;
  logic [15:0] dest_q, dest_d;
  logic [15:0] src_q, src_d;
  logic [15:0] cmd_q, cmd_d;
  logic [7:0]  hdr_sum_q, hdr_sum_d;
  logic [7:0]  dchk_q, dchk_d;
  logic [7:0]  pay_sum_q, pay_sum_d;
  logic [15:0] left_q, left_d;

  // result register
  logic        out_valid_q;
  logic [7:0]  data_byte_q, data_byte_d;
  logic        data_valid_q, data_valid_d;
  logic        frame_end_q, frame_end_d;
  status_e     status_q, status_d;

  logic        in_fire;
  logic [3:0]  pos;
  logic        high;
  logic [15:0] len_sum;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // merge a byte into a 16-bit field: high byte clears the low half
  function automatic logic [15:0] put_byte(logic [15:0] word, logic [7:0] b, logic hi);
    put_byte = hi ? {b, 8'h00} : {word[15:8], b};
  endfunction

  // status at the last byte of a frame
  function automatic status_e final_status(logic [7:0] hsum, logic [7:0] dchk,
                                           logic [7:0] psum);
    logic [7:0] dsum;
    dsum = dchk + psum;
    if (hsum != 8'h00) final_status = STATUS_HDR_ERR;
    else if (dsum != 8'h00) final_status = STATUS_DATA_ERR;
    else final_status = STATUS_OK;
  endfunction

  // next frame state and result for the byte on the input
  always_comb begin
    hdr_pos_d    = hdr_pos_q;
    in_payload_d = in_payload_q;
    len_d        = len_q;
    len_cmp_d    = len_cmp_q;
    dest_d       = dest_q;
    src_d        = src_q;
    cmd_d        = cmd_q;
    hdr_sum_d    = hdr_sum_q;
    dchk_d       = dchk_q;
    pay_sum_d    = pay_sum_q;
    left_d       = left_q;
    data_byte_d  = 8'h00;
    data_valid_d = 1'b0;
    frame_end_d  = 1'b0;
    status_d     = STATUS_OK;
    // parity is taken before the out-of-range wrap
    high         = !hdr_pos_q[0];
    pos          = (hdr_pos_q >= HeaderBytes) ? PosLenHi : hdr_pos_q;
    len_sum      = 16'h0000;

    if (in_payload_q) begin
      data_byte_d  = rx_byte_i;
      data_valid_d = 1'b1;
      pay_sum_d    = (pay_sum_q + rx_byte_i) & ByteMask;
      left_d       = left_q - 16'd1;
      if (left_d == 16'h0000) begin
        frame_end_d  = 1'b1;
        status_d     = final_status(hdr_sum_q, dchk_q, pay_sum_d);
        hdr_pos_d    = 4'd0;
        in_payload_d = 1'b0;
        left_d       = 16'h0000;
      end
    end else begin
      if (pos == PosLenHi) begin
        hdr_sum_d = 8'h00;
        pay_sum_d = 8'h00;
      end
      if (pos <= PosHeadCheck) hdr_sum_d = hdr_sum_d + rx_byte_i;
      case (pos)
        4'd0, 4'd1: len_d     = put_byte(len_q, rx_byte_i, high);
        4'd2, 4'd3: len_cmp_d = put_byte(len_cmp_q, rx_byte_i, high);
        4'd4, 4'd5: dest_d    = put_byte(dest_q, rx_byte_i, high);
        4'd6, 4'd7: src_d     = put_byte(src_q, rx_byte_i, high);
        4'd8, 4'd9: cmd_d     = put_byte(cmd_q, rx_byte_i, high);
        PosDataCheck: dchk_d  = rx_byte_i;
        default: ;
      endcase
      hdr_pos_d = pos + 4'd1;
      len_sum   = len_d + len_cmp_d;
      if (pos == PosLenCmpLo && len_sum != 16'h0000) begin
        // bad length complement ends the frame early
        frame_end_d  = 1'b1;
        status_d     = STATUS_LEN_ERR;
        hdr_pos_d    = 4'd0;
        in_payload_d = 1'b0;
        left_d       = 16'h0000;
      end else if (pos == PosDataCheck) begin
        hdr_pos_d = 4'd0;
        if (len_q == 16'h0000) begin
          frame_end_d  = 1'b1;
          status_d     = final_status(hdr_sum_d, dchk_d, pay_sum_d);
          in_payload_d = 1'b0;
          left_d       = 16'h0000;
        end else begin
          in_payload_d = 1'b1;
          left_d       = len_q;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q    <= 4'd0;
      in_payload_q <= 1'b0;
      len_q        <= 16'h0000;
      len_cmp_q    <= 16'h0000;
      dest_q       <= 16'h0000;
      src_q        <= 16'h0000;
      cmd_q        <= 16'h0000;
      hdr_sum_q    <= 8'h00;
      dchk_q       <= 8'h00;
      pay_sum_q    <= 8'h00;
      left_q       <= 16'h0000;
    end else if (in_fire) begin
      hdr_pos_q    <= hdr_pos_d;
      in_payload_q <= in_payload_d;
      len_q        <= len_d;
      len_cmp_q    <= len_cmp_d;
      dest_q       <= dest_d;
      src_q        <= src_d;
      cmd_q        <= cmd_d;
      hdr_sum_q    <= hdr_sum_d;
      dchk_q       <= dchk_d;
      pay_sum_q    <= pay_sum_d;
      left_q       <= left_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output payload; header fields read back from the state registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_byte_q  <= data_byte_d;
      data_valid_q <= data_valid_d;
      frame_end_q  <= frame_end_d;
      status_q     <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = data_byte_q;
  assign data_valid_o   = data_valid_q;
  assign frame_end_o    = frame_end_q;
  assign status_o       = status_q;
  assign to_address_o   = dest_q;
  assign from_address_o = src_q;
  assign command_o      = cmd_q;
  assign frame_length_o = len_q;

  // checks
`include "assert_macros.svh"
  `ASSERT_CLK(a_status_only_at_end, out_valid_o && !frame_end_o |-> status_o == STATUS_OK, "status set without frame end")
  `ASSERT_CLK(a_payload_has_bytes, in_payload_q |-> left_q != 16'h0000, "payload with no bytes left")
  `ASSERT_CLK(a_hdr_pos_range, !in_payload_q |-> hdr_pos_q <= PosDataCheck, "header position out of range")
  `ASSERT_NEXT(a_pass_through, in_fire && in_payload_q, out_valid_o && data_valid_o && data_byte_o == $past(rx_byte_i), "payload byte not passed")

endmodule

`default_nettype wire
